// ----- design/ifmt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ifmt_pkg;

    localparam int VALUE_W  = 64;
    localparam int WIDTH_W  = 6;
    localparam int DIGITS   = 20;             // decimal digits of a 64-bit magnitude
    localparam int IDX_W    = 5;
    localparam int ITER_W   = 6;

    localparam logic [1:0] MODE_SDEC = 2'd0;
    localparam logic [1:0] MODE_UDEC = 2'd1;
    localparam logic [1:0] MODE_HEX  = 2'd2;
    localparam logic [1:0] MODE_PTR  = 2'd3;

    localparam logic [IDX_W-1:0] DEC_TOP = 5'd19;
    localparam logic [IDX_W-1:0] HEX_TOP = 5'd15;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] CHAR_A_OFS = 8'h57;   // 'a' - 10

    typedef enum logic [3:0] {
        S_IDLE,
        S_CONV,
        S_SCAN,
        S_SETUP,
        S_LEAD,
        S_X,
        S_SIGN,
        S_FILL,
        S_DIGITS
    } state_t;

    typedef enum logic [2:0] {
        CH_ZERO,
        CH_X,
        CH_MINUS,
        CH_SPACE,
        CH_DIGIT
    } char_sel_t;

    typedef struct packed {
        logic      load;
        logic      conv_step;
        logic      scan_step;
        logic      setup;
        logic      emit;
        logic      fill_dec;
        char_sel_t sel;
        logic      last;
    } cmd_t;

    typedef struct packed {
        logic conv_last;
        logic scan_done;
        logic ptr;
        logic neg;
        logic left;
        logic zp;
        logic fill_zero;
        logic fill_last;
        logic dig_last;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ----- design/integer_field_formatter_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Integer field formatter: one printf-style integer conversion per item.
// Input channel (item_valid / item_stall) carries mode, value, is_long,
// width, zero_pad and left_justify. Output channel (char_valid /
// char_stall) carries one ASCII character per transfer in out_char, with
// last set on the final character of the item.
// Sequence, one item at a time:
//   - decimal modes: an accept step, double-dabble conversion (one bit of
//     the 64-bit magnitude per cycle through 20 BCD digits), then a
//     leading-zero scan over the digit register and a setup step.
//   - hex: digits load directly, then the scan and the setup step.
//   - pointer: scan ends at once, then setup; always 18 characters.
//   Characters leave the output register (up to 63) at one per cycle unless
//   the receiver stalls; the next item is accepted the cycle after the final
//   character is loaded, while that character may still wait to be taken.
// item_stall is high whenever an item is in progress.
// A stalled receiver holds out_char/last steady and pauses the sequencer;
// nothing is dropped.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and clears
// the output valid; the digit register needs no reset since each item
// writes it before reading.

module integer_field_formatter_top
    import ifmt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic [1:0]         mode,
    input  wire logic [VALUE_W-1:0] value,
    input  wire logic               is_long,
    input  wire logic [WIDTH_W-1:0] width,
    input  wire logic               zero_pad,
    input  wire logic               left_justify,
    output logic                    char_valid,
    input  wire logic               char_stall,
    output logic [7:0]              out_char,
    output logic                    last
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer: conversion, scan, then sign / fill / digit ordering
    ifmt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .mode       (mode),
        .stat       (stat),
        .cmd        (cmd)
    );

    // digit register, counters and output register
    ifmt_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .mode         (mode),
        .value        (value),
        .is_long      (is_long),
        .width        (width),
        .zero_pad     (zero_pad),
        .left_justify (left_justify),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .out_char     (out_char),
        .last         (last)
    );

endmodule

`default_nettype wire

// ----- design/ifmt_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ifmt_datapath
    import ifmt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output stat_t                   stat,
    input  wire logic [1:0]         mode,
    input  wire logic [VALUE_W-1:0] value,
    input  wire logic               is_long,
    input  wire logic [WIDTH_W-1:0] width,
    input  wire logic               zero_pad,
    input  wire logic               left_justify,
    output logic                    char_valid,
    input  wire logic               char_stall,
    output logic [7:0]              out_char,
    output logic                    last
);

    logic [3:0]         digs_reg  [DIGITS];
    logic [3:0]         digs_next [DIGITS];
    logic [3:0]         adj       [DIGITS];
    logic [VALUE_W-1:0] mag_reg;
    logic [ITER_W-1:0]  iter_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [WIDTH_W-1:0] fill_reg;
    logic [WIDTH_W-1:0] wid_reg;
    logic               ptr_reg;
    logic               neg_reg;
    logic               left_reg;
    logic               zp_reg;
    logic [7:0]         out_char_reg;
    logic               last_reg;
    logic               out_valid_reg;

    logic [VALUE_W-1:0] ext;
    logic [VALUE_W-1:0] mag;
    logic [4*DIGITS-1:0] hex_digs;
    logic               neg;
    logic               is_hex;
    logic [WIDTH_W-1:0] wid;
    logic [WIDTH_W-1:0] cnt;
    logic [WIDTH_W-1:0] fill_calc;
    logic [3:0]         cur_dig;
    logic [7:0]         dig_char;
    logic [7:0]         sel_char;
    logic               out_free;

    // argument extension and magnitude
    always_comb
    begin
        if (is_long || mode == MODE_PTR)
        begin
            ext = value;
        end
        else if (mode == MODE_SDEC && value[31])
        begin
            ext = {32'hffff_ffff, value[31:0]};
        end
        else
        begin
            ext = {32'h0, value[31:0]};
        end
        neg    = (mode == MODE_SDEC) && ext[VALUE_W-1];
        mag    = neg ? (~ext + 64'd1) : ext;
        is_hex = (mode == MODE_HEX) || (mode == MODE_PTR);
        wid    = (neg && width != '0) ? width - 6'd1 : width;
    end

    // hex nibbles spread over the digit slots, upper slots zero
    assign hex_digs = {{(4*DIGITS-VALUE_W){1'b0}}, mag};

    // double dabble step: add 3 to each digit at 5 or above, then shift in one bit
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            adj[i] = (digs_reg[i] >= 4'd5) ? digs_reg[i] + 4'd3 : digs_reg[i];
        end
        digs_next[0] = {adj[0][2:0], mag_reg[VALUE_W-1]};
        for (int i = 1; i < DIGITS; i++)
        begin
            digs_next[i] = {adj[i][2:0], adj[i-1][3]};
        end
    end

    assign cur_dig   = digs_reg[idx_reg];
    assign dig_char  = (cur_dig < 4'd10) ? CHAR_ZERO + {4'd0, cur_dig}
                                         : CHAR_A_OFS + {4'd0, cur_dig};
    assign cnt       = {1'b0, idx_reg} + 6'd1;
    assign fill_calc = (wid_reg > cnt) ? wid_reg - cnt : '0;
    assign out_free  = !out_valid_reg || !char_stall;

    always_comb
    begin
        case (cmd.sel)
            CH_ZERO:  sel_char = CHAR_ZERO;
            CH_X:     sel_char = CHAR_X;
            CH_MINUS: sel_char = CHAR_MINUS;
            CH_SPACE: sel_char = CHAR_SPACE;
            CH_DIGIT: sel_char = dig_char;
            default:  sel_char = CHAR_SPACE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < DIGITS; i++)
            begin
                digs_reg[i] <= is_hex ? hex_digs[4*i +: 4] : 4'd0;
            end
            mag_reg  <= mag;
            // pointer has a fixed field: no fill
            wid_reg  <= (mode == MODE_PTR) ? '0 : wid;
            ptr_reg  <= (mode == MODE_PTR);
            neg_reg  <= neg;
            left_reg <= left_justify;
            zp_reg   <= zero_pad;
        end
        else if (cmd.conv_step)
        begin
            for (int i = 0; i < DIGITS; i++)
            begin
                digs_reg[i] <= digs_next[i];
            end
            mag_reg <= {mag_reg[VALUE_W-2:0], 1'b0};
        end
        if (cmd.emit)
        begin
            out_char_reg <= sel_char;
            last_reg     <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg      <= '0;
            idx_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                iter_reg <= '0;
                idx_reg  <= is_hex ? HEX_TOP : DEC_TOP;
            end
            else if (cmd.conv_step)
            begin
                iter_reg <= iter_reg + 6'd1;
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= idx_reg - 5'd1;
            end
            else if (cmd.emit && cmd.sel == CH_DIGIT && idx_reg != '0)
            begin
                idx_reg <= idx_reg - 5'd1;
            end

            if (cmd.setup)
            begin
                fill_reg <= fill_calc;
            end
            else if (cmd.fill_dec)
            begin
                fill_reg <= fill_reg - 6'd1;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!char_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.conv_last = (iter_reg == '1);
        stat.scan_done = ptr_reg || (idx_reg == '0) || (cur_dig != 4'd0);
        stat.ptr       = ptr_reg;
        stat.neg       = neg_reg;
        stat.left      = left_reg;
        stat.zp        = zp_reg;
        stat.fill_zero = (fill_reg == '0);
        stat.fill_last = (fill_reg == 6'd1);
        stat.dig_last  = (idx_reg == '0);
        stat.out_free  = out_free;
    end

    assign char_valid = out_valid_reg;
    assign out_char   = out_char_reg;
    assign last       = last_reg;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= DEC_TOP)
        else $error("digit index out of range");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("character overwrote an untaken output");

    a_idx_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.sel == CH_DIGIT && idx_reg != '0)
        |=> idx_reg == $past(idx_reg) - 5'd1)
        else $error("digit index did not step down");
`endif

endmodule

`default_nettype wire

// ----- design/ifmt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ifmt_ctrl
    import ifmt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire logic [1:0] mode,
    input  wire stat_t      stat,
    output cmd_t            cmd
);

    state_t state_reg;
    state_t state_next;
    logic   is_dec;

    assign is_dec = (mode == MODE_SDEC) || (mode == MODE_UDEC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = is_dec ? S_CONV : S_SCAN;
                end
            end
            S_CONV:
            begin
                if (stat.conv_last)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                if (stat.ptr)
                begin
                    state_next = S_LEAD;
                end
                else if (stat.left)
                begin
                    state_next = stat.neg ? S_SIGN : S_DIGITS;
                end
                else if (stat.zp)
                begin
                    state_next = stat.neg ? S_SIGN : (stat.fill_zero ? S_DIGITS : S_FILL);
                end
                else
                begin
                    state_next = !stat.fill_zero ? S_FILL : (stat.neg ? S_SIGN : S_DIGITS);
                end
            end
            S_LEAD:
            begin
                if (stat.out_free)
                begin
                    state_next = S_X;
                end
            end
            S_X:
            begin
                if (stat.out_free)
                begin
                    state_next = S_DIGITS;
                end
            end
            S_SIGN:
            begin
                if (stat.out_free)
                begin
                    if (!stat.left && stat.zp && !stat.fill_zero)
                    begin
                        state_next = S_FILL;
                    end
                    else
                    begin
                        state_next = S_DIGITS;
                    end
                end
            end
            S_FILL:
            begin
                if (stat.out_free && stat.fill_last)
                begin
                    if (stat.left)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (!stat.zp && stat.neg)
                    begin
                        state_next = S_SIGN;
                    end
                    else
                    begin
                        state_next = S_DIGITS;
                    end
                end
            end
            S_DIGITS:
            begin
                if (stat.out_free && stat.dig_last)
                begin
                    state_next = (stat.left && !stat.fill_zero) ? S_FILL : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd           = '0;
        cmd.sel       = CH_SPACE;
        item_stall    = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = item_valid;
            end
            S_CONV:
            begin
                cmd.conv_step = 1'b1;
            end
            S_SCAN:
            begin
                cmd.scan_step = !stat.scan_done;
                cmd.setup     = stat.scan_done;
            end
            S_LEAD:
            begin
                cmd.emit = stat.out_free;
                cmd.sel  = CH_ZERO;
            end
            S_X:
            begin
                cmd.emit = stat.out_free;
                cmd.sel  = CH_X;
            end
            S_SIGN:
            begin
                cmd.emit = stat.out_free;
                cmd.sel  = CH_MINUS;
            end
            S_FILL:
            begin
                cmd.emit     = stat.out_free;
                cmd.fill_dec = stat.out_free;
                cmd.sel      = (stat.zp && !stat.left) ? CH_ZERO : CH_SPACE;
                cmd.last     = stat.left && stat.fill_last;
            end
            S_DIGITS:
            begin
                cmd.emit = stat.out_free;
                cmd.sel  = CH_DIGIT;
                cmd.last = stat.dig_last && !(stat.left && !stat.fill_zero);
            end
            default:
            begin
                cmd.sel = CH_SPACE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> state_reg == S_IDLE)
        else $error("final character did not end the item");

    a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL && cmd.emit) |-> !stat.fill_zero)
        else $error("fill character emitted with empty fill count");

    a_conv_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CONV && !stat.conv_last) |=> state_reg == S_CONV)
        else $error("conversion left early");
`endif

endmodule

`default_nettype wire

// ----- verif/integer_field_formatter_top_test.sv -----
`timescale 1ns / 1ps

// Standalone check of integer_field_formatter_top.
// A directed table covers the field extremes, every conversion and the
// sign/fill corner cases. A long random run follows. Every accepted directive
// is turned into its expected character string here. Every character taken
// from the block is compared in order against that string.

module integer_field_formatter_top_test;
    import ifmt_pkg::*;

    localparam int CLK_HALF     = 2;          // 4 ns period
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 355;        // plus the directed rows, ~380 total
    localparam int DRAIN_CYCLES = 200;        // > worst decimal latency plus a field
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int TEXT_BYTES   = 20;         // longest typed result
    localparam int DIRECTED_N   = 25;

    localparam logic [7:0] ASC_ZERO  = "0";
    localparam logic [7:0] ASC_LOW_A = "a";
    localparam logic [7:0] ASC_X     = "x";
    localparam logic [7:0] ASC_MINUS = "-";
    localparam logic [7:0] ASC_SPACE = " ";

    localparam logic [VALUE_W-1:0] ALL_ONES = '1;
    localparam logic [VALUE_W-1:0] MIN_S64  = 64'h8000_0000_0000_0000;

    // One directive. The member order matches the input ports, so a struct can
    // be driven onto them as a single concatenation.
    typedef struct packed {
        logic [1:0]         mode;
        logic [VALUE_W-1:0] value;
        logic               is_long;
        logic [WIDTH_W-1:0] width;
        logic               zero_pad;
        logic               left_justify;
    } directive_t;

    // The text is right-aligned ASCII. All zeros means the expected text comes
    // from the formatter model below.
    typedef struct packed {
        directive_t              stim;
        logic [TEXT_BYTES*8-1:0] text;
    } directed_row_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_t;

    localparam directed_row_t DIRECTED_ROWS [DIRECTED_N] = '{
        // zero, and -1 from a short argument
        '{'{MODE_SDEC, 64'd0,                  1'b0, 6'd0,  1'b0, 1'b0}, "0"},
        '{'{MODE_SDEC, 64'hFFFF_FFFF,          1'b0, 6'd0,  1'b0, 1'b0}, "-1"},
        // the most negative 64-bit value prints its full magnitude
        '{'{MODE_SDEC, MIN_S64,                1'b1, 6'd0,  1'b0, 1'b0},
          "-9223372036854775808"},
        '{'{MODE_UDEC, ALL_ONES,               1'b1, 6'd0,  1'b0, 1'b0},
          "18446744073709551615"},
        '{'{MODE_HEX,  ALL_ONES,               1'b1, 6'd0,  1'b0, 1'b0}, "ffffffffffffffff"},
        // pointer ignores width, fill, justify and is_long
        '{'{MODE_PTR,  64'd0,                  1'b0, 6'd0,  1'b0, 1'b0}, "0x0000000000000000"},
        '{'{MODE_PTR,  ALL_ONES,               1'b0, 6'd63, 1'b1, 1'b1}, "0xffffffffffffffff"},
        // -5 in a width of 4 under every fill/justify combination
        '{'{MODE_SDEC, 64'hFFFF_FFFB,          1'b0, 6'd4,  1'b0, 1'b0}, "  -5"},
        '{'{MODE_SDEC, 64'hFFFF_FFFB,          1'b0, 6'd4,  1'b1, 1'b0}, "-005"},
        '{'{MODE_SDEC, 64'hFFFF_FFFB,          1'b0, 6'd4,  1'b0, 1'b1}, "-5  "},
        '{'{MODE_SDEC, 64'hFFFF_FFFB,          1'b0, 6'd4,  1'b1, 1'b1}, "-5  "},
        // upper half ignored on a short argument
        '{'{MODE_UDEC, 64'hDEAD_BEEF_0000_0042, 1'b0, 6'd0, 1'b0, 1'b0}, "66"},
        '{'{MODE_SDEC, 64'h7FFF_FFFF,          1'b0, 6'd0,  1'b0, 1'b0}, "2147483647"},
        '{'{MODE_SDEC, 64'h8000_0000,          1'b0, 6'd0,  1'b0, 1'b0}, "-2147483648"},
        // width below the digit count: no truncation
        '{'{MODE_HEX,  64'h1234_ABCD,          1'b0, 6'd2,  1'b0, 1'b0}, "1234abcd"},
        '{'{MODE_SDEC, 64'h8000_0000,          1'b1, 6'd0,  1'b0, 1'b0}, "2147483648"},
        // full-width fields, then a zero short argument in a zero-padded width of 5
        '{'{MODE_UDEC, 64'd0,                  1'b0, 6'd63, 1'b1, 1'b0}, '0},
        '{'{MODE_SDEC, ALL_ONES,               1'b1, 6'd63, 1'b0, 1'b0}, '0},
        '{'{MODE_HEX,  64'hFF,                 1'b0, 6'd63, 1'b0, 1'b1}, '0},
        '{'{MODE_SDEC, 64'hFFFF_FFFF_0000_0000, 1'b0, 6'd5, 1'b1, 1'b0}, "00000"},
        // a negative value with width 1 loses its only fill slot to the sign
        '{'{MODE_SDEC, ALL_ONES,               1'b1, 6'd1,  1'b1, 1'b0}, "-1"},
        '{'{MODE_PTR,  64'h0123_4567_89AB_CDEF, 1'b1, 6'd7, 1'b0, 1'b0}, "0x0123456789abcdef"},
        '{'{MODE_HEX,  64'hA,                  1'b0, 6'd3,  1'b1, 1'b0}, "00a"},
        '{'{MODE_UDEC, 64'd42,                 1'b0, 6'd5,  1'b0, 1'b1}, "42   "},
        '{'{MODE_SDEC, MIN_S64,                1'b1, 6'd63, 1'b1, 1'b0}, '0}
    };

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    logic [1:0]         mode;
    logic [VALUE_W-1:0] value;
    logic               is_long;
    logic [WIDTH_W-1:0] width;
    logic               zero_pad;
    logic               left_justify;
    logic               char_valid;
    logic               char_stall;
    logic [7:0]         out_char;
    logic               last;

    char_t expected_chars [$];     // characters still owed by the block, in order
    int    mismatch_count = 0;
    int    chars_checked  = 0;
    int    items_sent     = 0;
    int    mode_items [4] = '{0, 0, 0, 0};
    int    burst_left     = 1;
    int    cycle_count    = 0;

    integer_field_formatter_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .mode         (mode),
        .value        (value),
        .is_long      (is_long),
        .width        (width),
        .zero_pad     (zero_pad),
        .left_justify (left_justify),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .out_char     (out_char),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Formatter model: appends the characters of one directive to expected_chars.
    function automatic void format_field(input directive_t d);
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] radix;
        logic [7:0]         nib;
        logic [7:0]         digits [$];
        logic [7:0]         line [$];
        logic [7:0]         fill_ch;
        int                 field_w;
        bit                 neg;
        mag     = d.value;
        field_w = d.width;
        neg     = 1'b0;
        if (d.mode != MODE_PTR && !d.is_long)
        begin
            // short argument: sign-extend for signed decimal, else zero-extend
            if (d.mode == MODE_SDEC)
                mag = {{32{d.value[31]}}, d.value[31:0]};
            else
                mag = {32'd0, d.value[31:0]};
        end
        if (d.mode == MODE_SDEC && mag[VALUE_W-1])
        begin
            neg     = 1'b1;
            mag     = -mag;
            field_w = (field_w > 0) ? field_w - 1 : 0;
        end
        radix = (d.mode == MODE_SDEC || d.mode == MODE_UDEC) ? 64'd10 : 64'd16;
        do
        begin
            nib = 8'(mag % radix);
            digits.push_front(nib < 8'd10 ? ASC_ZERO + nib : ASC_LOW_A + nib - 8'd10);
            mag = mag / radix;
        end while (mag != 0);

        if (d.mode == MODE_PTR)
        begin
            while (digits.size() < 16)
                digits.push_front(ASC_ZERO);
            line = {ASC_ZERO, ASC_X, digits};
        end
        else if (d.left_justify)
        begin
            // zero_pad has no effect here: trailing fill is always spaces
            if (neg)
                line.push_back(ASC_MINUS);
            line = {line, digits};
            for (int k = digits.size(); k < field_w; k++)
                line.push_back(ASC_SPACE);
        end
        else
        begin
            // zero fill puts the sign ahead of the zeros, space fill after the spaces
            fill_ch = d.zero_pad ? ASC_ZERO : ASC_SPACE;
            if (neg && d.zero_pad)
                line.push_back(ASC_MINUS);
            for (int k = digits.size(); k < field_w; k++)
                line.push_back(fill_ch);
            if (neg && !d.zero_pad)
                line.push_back(ASC_MINUS);
            line = {line, digits};
        end

        foreach (line[k])
            expected_chars.push_back('{line[k], k == line.size() - 1});
    endfunction

    // Present one directive from the falling edge and hold it until accepted.
    // A zero text means the expected characters come from format_field.
    // Bursts: valid stays high between items until the burst runs out, then
    // drops for a random gap, sometimes long enough to land anywhere in the
    // block's conversion.
    task automatic send_item(input directive_t d, input logic [TEXT_BYTES*8-1:0] text);
        int    gap;
        char_t typed [$];
        item_valid <= 1'b1;
        {mode, value, is_long, width, zero_pad, left_justify} <= d;
        do
            @(posedge clk);
        while (item_stall);

        items_sent++;
        mode_items[d.mode]++;
        if (text == '0)
            format_field(d);
        else
        begin
            for (int b = TEXT_BYTES - 1; b >= 0; b--)
                if (text[b*8 +: 8] != 8'd0)
                    typed.push_back('{text[b*8 +: 8], 1'b0});
            typed[typed.size() - 1].last = 1'b1;
            expected_chars = {expected_chars, typed};
        end

        @(negedge clk);
        burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 120) : $urandom_range(1, 4);
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Receiver stall pattern: each span of random length picks one of
    // never, light, heavy and periodic stalling.
    initial
    begin
        int rcv_style;
        int span;
        int phase;
        char_stall = 1'b0;
        phase      = 0;
        forever
        begin
            rcv_style = $urandom_range(0, 3);
            span      = $urandom_range(20, 200);
            repeat (span)
            begin
                @(negedge clk);
                phase++;
                case (rcv_style)
                    0:       char_stall <= 1'b0;
                    1:       char_stall <= ($urandom_range(0, 3) == 0);
                    2:       char_stall <= ($urandom_range(0, 3) != 0);
                    default: char_stall <= (phase % 3 == 0);
                endcase
            end
        end
    end

    // Character checker: every character taken is matched against the oldest
    // expected one.
    always @(posedge clk)
    begin
        char_t want;
        if (rst_n && char_valid && !char_stall)
        begin
            chars_checked++;
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected character: expected none, actual char %h last %b",
                         $time, out_char, last);
                mismatch_count++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (out_char !== want.ch)
                begin
                    $display("%0t: out_char mismatch: expected %h, actual %h",
                             $time, want.ch, out_char);
                    mismatch_count++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, want.last, last);
                    mismatch_count++;
                end
            end
        end
    end

    // Run limit, far above the slowest correct run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d characters pending", $time, expected_chars.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        directive_t pick;
        int         shape;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        {mode, value, is_long, width, zero_pad, left_justify} = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        foreach (DIRECTED_ROWS[r])
            send_item(DIRECTED_ROWS[r].stim, DIRECTED_ROWS[r].text);

        // random directives, biased toward the sign and word boundaries
        repeat (RANDOM_ITEMS)
        begin
            shape              = $urandom_range(0, 5);
            pick.mode          = 2'($urandom_range(0, 3));
            pick.value         = {$urandom, $urandom};
            pick.is_long       = 1'($urandom_range(0, 1));
            pick.zero_pad      = 1'($urandom_range(0, 1));
            pick.left_justify  = 1'($urandom_range(0, 1));
            pick.width         = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                             : 6'($urandom_range(0, 24));
            case (shape)
                0: pick.value = 64'($urandom_range(0, 999));
                1:
                begin
                    // small 32-bit magnitude, either sign, garbage upper half
                    pick.value[31:0] = 32'($urandom_range(0, 20));
                    if (pick.value[40])
                        pick.value[31:0] = -pick.value[31:0];
                end
                2:
                begin
                    pick.value = 64'($urandom_range(0, 20));
                    if ($urandom_range(0, 1) == 1)
                        pick.value = -pick.value;
                end
                3: pick.value = MIN_S64 + 64'($urandom_range(0, 4)) - 64'd2;
                4: pick.value[31:0] = 32'h8000_0000 + 32'($urandom_range(0, 4)) - 32'd2;
                default: ;
            endcase
            send_item(pick, '0);
        end
        item_valid <= 1'b0;

        // drain, then watch a while longer for stray characters
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Formatted %0d directives: %0d signed, %0d unsigned, %0d hex, %0d pointer.",
                 items_sent, mode_items[MODE_SDEC], mode_items[MODE_UDEC],
                 mode_items[MODE_HEX], mode_items[MODE_PTR]);
        $display("Compared %0d characters under random stalls, %0d mismatches.",
                 chars_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
